// ===== src/urxmv_pkg.sv =====
// Shared types and constants for the oversampling UART receiver with majority vote.
package urxmv_pkg;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    typedef enum logic [CFG_AW-1:0] {
        REG_IDLE_TIMEOUT    = 3'd0,
        REG_FIRST_BIT_START = 3'd1,
        REG_SAMPLES_PER_BIT = 3'd2,
        REG_VOTE_THRESHOLD  = 3'd3,
        REG_FRAME_LENGTH    = 3'd4
    } cfg_reg_t;

    localparam logic [15:0] RST_IDLE_TIMEOUT    = 16'd10000;
    localparam logic [7:0]  RST_FIRST_BIT_START = 8'd12;
    localparam logic [4:0]  RST_SAMPLES_PER_BIT = 5'd10;
    localparam logic [4:0]  RST_VOTE_THRESHOLD  = 5'd4;
    localparam logic [7:0]  RST_FRAME_LENGTH    = 8'd117;

    typedef struct packed {
        logic [15:0] idle_timeout;
        logic [7:0]  first_bit_start;
        logic [4:0]  samples_per_bit;
        logic [4:0]  vote_threshold;
        logic [7:0]  frame_length;
    } cfg_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       timed_out;
    } result_t;

endpackage

// ===== src/uart_rx_majority_vote_top.sv =====
// Throughput: one line sample per cycle unless a result is held by m_ready; the
// state update for a sample is a single pass of decision logic between the input
// register and the result register. A result waits in the output register while
// the next sample is taken in.
// Reset (aresetn, synchronous, active low) clears state, empties both registers and
// loads the configuration defaults.
module uart_rx_majority_vote_top #(
    parameter int DATA_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_line_level,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_data_byte,
    output logic                              m_timed_out,
    input  logic                              cfg_we,
    input  logic [urxmv_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [urxmv_pkg::CFG_DW-1:0]      cfg_wdata
);
    import urxmv_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic       stage_valid_reg, stage_valid_next;
    logic       stage_level_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg;
    logic       out_timed_out_reg;
    logic       advance;

    assign advance = stage_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !stage_valid_reg || advance;

    urxmv_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    urxmv_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .line_level (stage_level_reg),
        .cfg        (cfg),
        .result     (result)
    );

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (s_valid && s_ready)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = result.valid;
        else if (m_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready)
            stage_level_reg <= s_line_level;
        if (advance && result.valid) begin
            out_data_reg      <= result.data_byte;
            out_timed_out_reg <= result.timed_out;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_data_byte = out_data_reg;
    assign m_timed_out = out_timed_out_reg;

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (stage_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_timeout_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_timed_out) |-> (m_data_byte == 8'd0))
        else $error("timeout result carries nonzero data");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg && !advance) |=> (stage_valid_reg && $stable(stage_level_reg)))
        else $error("stalled sample lost");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg || m_ready) && !advance |=> !out_valid_reg)
        else $error("result appeared without a processed sample");

endmodule

// ===== src/urxmv_cfg.sv =====
// Configuration register file for the UART receiver.
module urxmv_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [urxmv_pkg::CFG_AW-1:0]      cfg_addr,
    input  logic [urxmv_pkg::CFG_DW-1:0]      cfg_wdata,
    output urxmv_pkg::cfg_t                   cfg
);
    import urxmv_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_IDLE_TIMEOUT:    cfg_next.idle_timeout    = cfg_wdata[15:0];
                REG_FIRST_BIT_START: cfg_next.first_bit_start = cfg_wdata[7:0];
                REG_SAMPLES_PER_BIT: cfg_next.samples_per_bit = cfg_wdata[4:0];
                REG_VOTE_THRESHOLD:  cfg_next.vote_threshold  = cfg_wdata[4:0];
                REG_FRAME_LENGTH:    cfg_next.frame_length    = cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_timeout    <= RST_IDLE_TIMEOUT;
            cfg_reg.first_bit_start <= RST_FIRST_BIT_START;
            cfg_reg.samples_per_bit <= RST_SAMPLES_PER_BIT;
            cfg_reg.vote_threshold  <= RST_VOTE_THRESHOLD;
            cfg_reg.frame_length    <= RST_FRAME_LENGTH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/urxmv_core.sv =====
// Receiver state and per-sample decision logic: idle timeout, start detect, bit voting.
module urxmv_core #(
    parameter int DATA_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                line_level,
    input  urxmv_pkg::cfg_t     cfg,
    output urxmv_pkg::result_t  result
);
    import urxmv_pkg::*;

    localparam int KW = $clog2(DATA_BITS + 1);
    localparam int MW = (5 + KW > 9) ? 5 + KW : 9;

    logic        receiving_reg, receiving_next;
    logic [15:0] idle_count_reg, idle_count_next;
    logic [7:0]  sample_index_reg, sample_index_next;
    logic [4:0]  high_votes_reg, high_votes_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;

    logic [DATA_BITS-1:0] ge;
    logic [DATA_BITS-1:0] eq_end;
    logic [KW-1:0]        k;
    logic [7:0]           off;
    logic [MW-1:0]        off_w;
    logic                 in_window;
    logic                 win_end;
    logic                 frame_end;
    logic [7:0]           flen;
    logic [15:0]          limit;
    logic [15:0]          idle_inc;
    logic [4:0]           votes_inc;
    logic                 bit_val;

    // Window boundaries are m*samples_per_bit past first_bit_start; the bit index
    // is the number of boundaries already passed.
    always_comb begin
        logic [MW-1:0] mult;
        mult  = '0;
        off   = sample_index_reg - cfg.first_bit_start;
        off_w = MW'(off);
        for (int m = 1; m <= DATA_BITS; m++) begin
            mult        = MW'(m) * MW'(cfg.samples_per_bit);
            ge[m-1]     = off_w >= mult;
            eq_end[m-1] = (off_w + MW'(1)) == mult;
        end
    end

    assign k         = KW'($countones(ge));
    assign win_end   = |eq_end;
    assign in_window = (cfg.samples_per_bit != 5'd0)
                     && (sample_index_reg >= cfg.first_bit_start)
                     && !ge[DATA_BITS-1];
    assign flen      = (cfg.frame_length != 8'd0) ? cfg.frame_length : 8'd1;
    assign frame_end = ({1'b0, sample_index_reg} + 9'd1) >= {1'b0, flen};
    assign limit     = (cfg.idle_timeout != 16'd0) ? cfg.idle_timeout : 16'd1;
    assign idle_inc  = idle_count_reg + 16'd1;
    assign votes_inc = high_votes_reg + {4'd0, line_level};
    assign bit_val   = votes_inc > cfg.vote_threshold;

    always_comb begin
        receiving_next    = receiving_reg;
        idle_count_next   = idle_count_reg;
        sample_index_next = sample_index_reg;
        high_votes_next   = high_votes_reg;
        shift_byte_next   = shift_byte_reg;
        result            = '0;
        if (step) begin
            if (!receiving_reg) begin
                if (line_level) begin
                    if (idle_inc >= limit) begin
                        idle_count_next  = '0;
                        result.valid     = 1'b1;
                        result.timed_out = 1'b1;
                    end else begin
                        idle_count_next = idle_inc;
                    end
                end else begin
                    receiving_next    = 1'b1;
                    idle_count_next   = '0;
                    sample_index_next = '0;
                    high_votes_next   = '0;
                    shift_byte_next   = '0;
                end
            end else begin
                if (in_window) begin
                    high_votes_next = votes_inc;
                    if (win_end || frame_end) begin
                        high_votes_next = '0;
                        // bits at position 8 and up are voted but have no byte slot
                        for (int j = 0; j < 8; j++) begin
                            if (j < DATA_BITS && k == KW'(j) && bit_val)
                                shift_byte_next[j] = 1'b1;
                        end
                    end
                end
                sample_index_next = sample_index_reg + 8'd1;
                if (frame_end) begin
                    result.valid      = 1'b1;
                    result.data_byte  = shift_byte_next;
                    receiving_next    = 1'b0;
                    idle_count_next   = '0;
                    sample_index_next = '0;
                    high_votes_next   = '0;
                    shift_byte_next   = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg    <= 1'b0;
            idle_count_reg   <= '0;
            sample_index_reg <= '0;
            high_votes_reg   <= '0;
            shift_byte_reg   <= '0;
        end else begin
            receiving_reg    <= receiving_next;
            idle_count_reg   <= idle_count_next;
            sample_index_reg <= sample_index_next;
            high_votes_reg   <= high_votes_next;
            shift_byte_reg   <= shift_byte_next;
        end
    end

    // while idle no frame state is carried
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !receiving_reg |-> (sample_index_reg == 8'd0 && shift_byte_reg == 8'd0))
        else $error("frame state not cleared while idle");

endmodule

// ===== tb/tb_uart_rx_majority_vote_top.sv =====
// Self-checking testbench for the oversampling UART receiver with per-bit majority vote.
`timescale 1ns / 1ps

module tb_uart_rx_majority_vote_top;
    import urxmv_pkg::*;

    localparam int DATA_BITS     = 8;
    localparam int RANDOM_ITEMS  = 450;
    localparam int DRAIN_CYCLES  = 4;
    localparam int END_WAIT      = 20;
    localparam int QUIET_LIMIT   = 4000;

    // index with no register behind it; writes must be ignored
    localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       timed_out;
    } rx_result_t;

    typedef enum {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_SPARSE} ready_mode_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_line_level;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [7:0]        m_data_byte;
    logic              m_timed_out;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;

    // receiver shadow state
    cfg_t       shadow;
    bit         rx_active;
    logic [15:0] idle_cnt;
    logic [7:0] samp_idx;
    logic [4:0] votes;
    logic [7:0] byte_acc;

    rx_result_t expected_bytes[$];
    int error_count   = 0;
    int samples_sent  = 0;
    int burst_left    = 0;
    int quiet_cycles  = 0;
    int ready_run     = 0;
    ready_mode_t ready_mode = RDY_ALWAYS;

    uart_rx_majority_vote_top #(
        .DATA_BITS(DATA_BITS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_line_level(s_line_level),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_byte (m_data_byte),
        .m_timed_out (m_timed_out),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_frame();
        samp_idx = '0;
        votes    = '0;
        byte_acc = '0;
    endfunction

    function automatic void reset_receiver_model();
        shadow.idle_timeout    = RST_IDLE_TIMEOUT;
        shadow.first_bit_start = RST_FIRST_BIT_START;
        shadow.samples_per_bit = RST_SAMPLES_PER_BIT;
        shadow.vote_threshold  = RST_VOTE_THRESHOLD;
        shadow.frame_length    = RST_FRAME_LENGTH;
        rx_active = 1'b0;
        idle_cnt  = '0;
        clear_frame();
    endfunction

    function automatic void apply_reg(input logic [CFG_AW-1:0] addr,
                                      input logic [CFG_DW-1:0] value);
        case (addr)
            REG_IDLE_TIMEOUT:    shadow.idle_timeout    = value[15:0];
            REG_FIRST_BIT_START: shadow.first_bit_start = value[7:0];
            REG_SAMPLES_PER_BIT: shadow.samples_per_bit = value[4:0];
            REG_VOTE_THRESHOLD:  shadow.vote_threshold  = value[4:0];
            REG_FRAME_LENGTH:    shadow.frame_length    = value[7:0];
            default: ;
        endcase
    endfunction

    // advance the receiver shadow by one line sample, queue the byte it yields
    function automatic void predict_line_sample(input logic lvl);
        int limit, flen, idx, off, k, spb;
        bit frame_end, win_end;
        if (!rx_active) begin
            if (lvl) begin
                limit = (shadow.idle_timeout == 0) ? 1 : int'(shadow.idle_timeout);
                idle_cnt = idle_cnt + 16'd1;
                if (int'(idle_cnt) >= limit) begin
                    idle_cnt = '0;
                    expected_bytes.push_back('{data_byte: 8'h00, timed_out: 1'b1});
                end
            end else begin
                rx_active = 1'b1;
                idle_cnt  = '0;
                clear_frame();
            end
        end else begin
            idx  = int'(samp_idx);
            spb  = int'(shadow.samples_per_bit);
            flen = (shadow.frame_length == 0) ? 1 : int'(shadow.frame_length);
            frame_end = (idx + 1) >= flen;
            if (spb != 0 && idx >= int'(shadow.first_bit_start)) begin
                off = idx - int'(shadow.first_bit_start);
                k   = off / spb;
                if (k < DATA_BITS) begin
                    win_end = (off % spb) == spb - 1;
                    if (lvl) votes = votes + 5'd1;
                    // a frame cut inside a window still decides that bit
                    if (win_end || frame_end) begin
                        if (votes > shadow.vote_threshold && k < 8) byte_acc[k] = 1'b1;
                        votes = '0;
                    end
                end
            end
            samp_idx = samp_idx + 8'd1;
            if (frame_end) begin
                expected_bytes.push_back('{data_byte: byte_acc, timed_out: 1'b0});
                rx_active = 1'b0;
                idle_cnt  = '0;
                clear_frame();
            end
        end
    endfunction

    // one line sample over the input channel; sender idles in bursts
    task automatic send_sample(input logic lvl);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                gap        = 0;
                burst_left = $urandom_range(50, 200);
            end else begin
                gap        = $urandom_range(0, 12);
                burst_left = $urandom_range(1, 24);
            end
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid      <= 1'b1;
        s_line_level <= lvl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_line_sample(lvl);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_pipeline();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (expected_bytes.size() != 0) @(negedge aclk);
        // samples that yield nothing may still be in flight
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        apply_reg(addr, value);
        @(negedge aclk);
    endtask

    // upper data bits of narrow registers carry junk that must be dropped
    task automatic set_config(input cfg_t c, input bit poke_unused);
        drain_pipeline();
        write_reg(REG_IDLE_TIMEOUT, c.idle_timeout);
        write_reg(REG_FIRST_BIT_START, {8'($urandom), c.first_bit_start});
        write_reg(REG_SAMPLES_PER_BIT, {11'($urandom), c.samples_per_bit});
        write_reg(REG_VOTE_THRESHOLD, {11'($urandom), c.vote_threshold});
        write_reg(REG_FRAME_LENGTH, {8'($urandom), c.frame_length});
        if (poke_unused) write_reg(REG_UNUSED, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    // idle highs, start low, then the data windows at the current settings
    task automatic send_frame(input logic [7:0] payload, input int noise_pct);
        int flen, k;
        logic lvl;
        repeat ($urandom_range(0, 6)) send_sample(1'b1);
        send_sample(1'b0);
        flen = (shadow.frame_length == 0) ? 1 : int'(shadow.frame_length);
        for (int i = 0; i < flen; i++) begin
            lvl = 1'b1;
            if (shadow.samples_per_bit != 0 && i >= int'(shadow.first_bit_start)) begin
                k = (i - int'(shadow.first_bit_start)) / int'(shadow.samples_per_bit);
                if (k < 8) lvl = payload[k];
            end
            if (int'($urandom_range(0, 99)) < noise_pct) lvl = ~lvl;
            send_sample(lvl);
        end
    endtask

    function automatic cfg_t random_config();
        cfg_t c;
        int fl;
        case ($urandom_range(0, 9))
            0:       c.idle_timeout = 16'd0;
            1:       c.idle_timeout = 16'hFFFF;
            2:       c.idle_timeout = 16'($urandom);
            default: c.idle_timeout = 16'($urandom_range(1, 40));
        endcase
        c.first_bit_start = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                         : 8'($urandom_range(0, 6));
        c.samples_per_bit = ($urandom_range(0, 9) == 0) ? 5'($urandom)
                                                         : 5'($urandom_range(1, 4));
        c.vote_threshold  = ($urandom_range(0, 9) == 0) ? 5'($urandom)
                                                         : 5'($urandom_range(0, c.samples_per_bit));
        case ($urandom_range(0, 19))
            0:       c.frame_length = 8'd0;
            1:       c.frame_length = 8'hFF;
            2:       c.frame_length = 8'($urandom);
            default: begin
                fl = int'(c.first_bit_start) + 8 * int'(c.samples_per_bit)
                     + int'($urandom_range(0, 8)) - 4;
                if (fl < 1) fl = 1;
                if (fl > 255) fl = 255;
                c.frame_length = 8'(fl);
            end
        endcase
        return c;
    endfunction

    task automatic test_reset_defaults();
        send_frame(8'hA5, 0);
        send_frame(8'h00, 0);
        send_frame(8'($urandom), 15);
    endtask

    task automatic test_directed_corners();
        cfg_t c;
        c = shadow;
        // zero timeout counts as one; unused index written alongside
        c.idle_timeout = 16'd0;
        set_config(c, 1'b1);
        repeat (2) send_sample(1'b1);
        // timeout lowered below a count already reached
        c.idle_timeout = 16'd3;
        set_config(c, 1'b0);
        repeat (2) send_sample(1'b1);
        c.idle_timeout = 16'd1;
        set_config(c, 1'b0);
        send_sample(1'b1);
        // zero frame length takes one sample
        c.first_bit_start = 8'd0;
        c.samples_per_bit = 5'd1;
        c.vote_threshold  = 5'd0;
        c.frame_length    = 8'd0;
        set_config(c, 1'b0);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b0);
        send_sample(1'b0);
        // zero bit width: no windows, all bits zero
        c.samples_per_bit = 5'd0;
        c.frame_length    = 8'd3;
        set_config(c, 1'b0);
        send_sample(1'b0);
        repeat (3) send_sample(1'b1);
        // frame ends inside the first window
        c.samples_per_bit = 5'd4;
        c.frame_length    = 8'd2;
        set_config(c, 1'b0);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b0);
        // frame length cut below the sample count mid frame
        c.samples_per_bit = 5'd1;
        c.frame_length    = 8'd10;
        set_config(c, 1'b0);
        send_sample(1'b0);
        repeat (5) send_sample(1'b1);
        c.frame_length = 8'd3;
        set_config(c, 1'b0);
        send_sample(1'b1);
    endtask

    task automatic test_extreme_settings();
        cfg_t c;
        c.idle_timeout    = 16'hFFFF;
        c.first_bit_start = 8'd0;
        c.samples_per_bit = 5'd31;
        c.vote_threshold  = 5'd30;
        c.frame_length    = 8'hFF;
        set_config(c, 1'b0);
        send_frame(8'($urandom), 0);
        // window start past the last sample index
        c.first_bit_start = 8'hFF;
        c.samples_per_bit = 5'd1;
        c.vote_threshold  = 5'd0;
        set_config(c, 1'b0);
        send_frame(8'hFF, 0);
        // threshold no count can exceed
        c.first_bit_start = 8'd0;
        c.samples_per_bit = 5'd31;
        c.vote_threshold  = 5'd31;
        set_config(c, 1'b0);
        send_frame(8'hFF, 0);
    endtask

    task automatic test_random_traffic();
        int items_start, noise;
        items_start = samples_sent;
        while (samples_sent - items_start < RANDOM_ITEMS) begin
            set_config(random_config(), 1'b0);
            repeat ($urandom_range(2, 8)) begin
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(1, 30)) send_sample(1'($urandom));
                end else begin
                    noise = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 35) : 0;
                    send_frame(8'($urandom), noise);
                end
            end
        end
    endtask

    // receiver stalls follow a mode that changes every so often
    always @(negedge aclk) begin
        if (ready_run == 0) begin
            ready_mode = ready_mode_t'($urandom_range(0, 3));
            ready_run  = $urandom_range(16, 160);
        end
        ready_run--;
        case (ready_mode)
            RDY_ALWAYS: m_ready <= 1'b1;
            RDY_HALF:   m_ready <= 1'($urandom);
            RDY_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
            default:    m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin : check_results
        rx_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected result transfer: data_byte=%h timed_out=%b",
                       m_data_byte, m_timed_out);
                error_count++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_data_byte !== want.data_byte) begin
                    $error("data_byte: expected %h, got %h", want.data_byte, m_data_byte);
                    error_count++;
                end
                if (m_timed_out !== want.timed_out) begin
                    $error("timed_out: expected %b, got %b", want.timed_out, m_timed_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_line_level = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        reset_receiver_model();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_directed_corners();
        test_extreme_settings();
        test_random_traffic();

        drain_pipeline();
        repeat (END_WAIT) @(negedge aclk);
        if (expected_bytes.size() != 0) begin
            $error("%0d expected results never arrived", expected_bytes.size());
            error_count++;
        end
        if (error_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

endmodule
